@@ rtl/core/epml_pkg.sv @@
`timescale 1ns / 1ps

package epml_pkg;

  // Fixed-point format and limits
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam int unsigned GAIN_W         = 24;
  localparam int unsigned INTEG_W        = 48;
  localparam int unsigned TERM_W         = 50;
  localparam int unsigned OPND_W         = 40;
  localparam int unsigned PROD_W         = 64;
  localparam int unsigned MPLR_W         = 24;
  localparam int unsigned DT_W           = 20;
  localparam int unsigned KDIV_SHIFT     = 10;

  localparam logic [7:0]            DUTY_MAX    = 8'd255;
  localparam logic [OPND_W-1:0]     OPND_LIM    = 40'h7F_FFFF_FFFF;
  localparam logic [MPLR_W-1:0]     USEC_PER_S  = 24'd1000000;
  localparam logic [KDIV_SHIFT-1:0] MILLI_DIV   = 10'd1000;
  localparam logic [31:0]           TARGET_RST  = 32'hFFFF_EC78;  // -5000

  localparam logic [GAIN_W-1:0] KP_RST = 24'd65536;
  localparam logic [GAIN_W-1:0] KD_RST = 24'd1638;
  localparam logic [GAIN_W-1:0] KI_RST = 24'd0;

  // Iteration counts of the shared multiplier and dividers
  localparam int unsigned MUL_STEPS  = 24;
  localparam int unsigned DIV_STEPS  = 64;
  localparam int unsigned KDIV_STEPS = 12;
  localparam int unsigned CNT_W      = 6;

  // Request types
  localparam logic [1:0] REQ_ENC    = 2'd0;
  localparam logic [1:0] REQ_TGT    = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_KP = 2'd0;
  localparam logic [1:0] REG_KD = 2'd1;
  localparam logic [1:0] REG_KI = 2'd2;

  // Datapath operations
  localparam logic [4:0] OP_NONE    = 5'd0;
  localparam logic [4:0] OP_ENC     = 5'd1;
  localparam logic [4:0] OP_TGT     = 5'd2;
  localparam logic [4:0] OP_LATCH   = 5'd3;
  localparam logic [4:0] OP_HOME    = 5'd4;
  localparam logic [4:0] OP_ERR     = 5'd5;
  localparam logic [4:0] OP_LD_INC  = 5'd6;
  localparam logic [4:0] OP_MUL     = 5'd7;
  localparam logic [4:0] OP_INTEG   = 5'd8;
  localparam logic [4:0] OP_LD_P    = 5'd9;
  localparam logic [4:0] OP_P_DONE  = 5'd10;
  localparam logic [4:0] OP_LD_DE   = 5'd11;
  localparam logic [4:0] OP_LD_DDIV = 5'd12;
  localparam logic [4:0] OP_DIV     = 5'd13;
  localparam logic [4:0] OP_LD_D    = 5'd14;
  localparam logic [4:0] OP_D_DONE  = 5'd15;
  localparam logic [4:0] OP_LD_IDIV = 5'd16;
  localparam logic [4:0] OP_LD_I    = 5'd17;
  localparam logic [4:0] OP_LD_I2   = 5'd18;
  localparam logic [4:0] OP_I_DONE  = 5'd19;
  localparam logic [4:0] OP_OUT     = 5'd20;
  localparam logic [4:0] OP_KDIV    = 5'd21;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } status_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] abs33(input logic [32:0] v);
    return v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic [GAIN_W-1:0] abs_gain(input logic [GAIN_W-1:0] v);
    return v[GAIN_W-1] ? (~v + GAIN_W'(1)) : v;
  endfunction

  function automatic logic [INTEG_W-1:0] abs_integ(input logic [INTEG_W-1:0] v);
    return v[INTEG_W-1] ? (~v + INTEG_W'(1)) : v;
  endfunction

  function automatic logic [OPND_W-1:0] clamp_opnd(input logic [PROD_W-1:0] q);
    return (q > PROD_W'(OPND_LIM)) ? OPND_LIM : q[OPND_W-1:0];
  endfunction

  function automatic logic [TERM_W-1:0] mk_term(input logic neg,
                                                input logic [TERM_W-2:0] mag);
    logic [TERM_W-1:0] m;
    m = {1'b0, mag};
    return neg ? (~m + TERM_W'(1)) : m;
  endfunction

endpackage

@@ rtl/core/epml_ctrl.sv @@
`timescale 1ns / 1ps

module epml_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output epml_pkg::cmd_t     cmd_o,
  input  epml_pkg::status_t  status_i
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_HOME  = 5'd1;
  localparam logic [4:0] S_ERR   = 5'd2;
  localparam logic [4:0] S_INC   = 5'd3;
  localparam logic [4:0] S_INTEG = 5'd4;
  localparam logic [4:0] S_PL    = 5'd5;
  localparam logic [4:0] S_PD    = 5'd6;
  localparam logic [4:0] S_DEL   = 5'd7;
  localparam logic [4:0] S_DDIV  = 5'd8;
  localparam logic [4:0] S_DL    = 5'd9;
  localparam logic [4:0] S_DD    = 5'd10;
  localparam logic [4:0] S_IDIV  = 5'd11;
  localparam logic [4:0] S_IL    = 5'd12;
  localparam logic [4:0] S_I2    = 5'd13;
  localparam logic [4:0] S_ID    = 5'd14;
  localparam logic [4:0] S_OUT   = 5'd15;
  localparam logic [4:0] S_MRUN  = 5'd16;
  localparam logic [4:0] S_DRUN  = 5'd17;
  localparam logic [4:0] S_KRUN  = 5'd18;

  logic [4:0]                    state_q, state_d;
  logic [4:0]                    ret_q, ret_d;
  logic [epml_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic                          accept;
  logic                          fire_out;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cnt_d     = cnt_q;
    cmd_o.op  = epml_pkg::OP_NONE;
    fire_out  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            epml_pkg::REQ_ENC:  cmd_o.op = epml_pkg::OP_ENC;
            epml_pkg::REQ_TGT:  cmd_o.op = epml_pkg::OP_TGT;
            epml_pkg::REQ_TICK: begin
              cmd_o.op = epml_pkg::OP_LATCH;
              state_d  = S_HOME;
            end
            default:            cmd_o.op = epml_pkg::OP_NONE;
          endcase
        end
      end
      S_HOME: begin
        cmd_o.op = epml_pkg::OP_HOME;
        state_d  = S_ERR;
      end
      S_ERR: begin
        cmd_o.op = epml_pkg::OP_ERR;
        state_d  = S_INC;
      end
      S_INC: begin
        cmd_o.op = epml_pkg::OP_LD_INC;
        ret_d    = S_INTEG;
        cnt_d    = '0;
        state_d  = S_MRUN;
      end
      S_INTEG: begin
        cmd_o.op = epml_pkg::OP_INTEG;
        state_d  = S_PL;
      end
      S_PL: begin
        cmd_o.op = epml_pkg::OP_LD_P;
        ret_d    = S_PD;
        cnt_d    = '0;
        state_d  = S_MRUN;
      end
      S_PD: begin
        cmd_o.op = epml_pkg::OP_P_DONE;
        state_d  = S_DEL;
      end
      S_DEL: begin
        cmd_o.op = epml_pkg::OP_LD_DE;
        ret_d    = S_DDIV;
        cnt_d    = '0;
        state_d  = S_MRUN;
      end
      S_DDIV: begin
        // skip the divide when no time has passed
        if (status_i.dt_zero) begin
          state_d = S_DL;
        end else begin
          cmd_o.op = epml_pkg::OP_LD_DDIV;
          ret_d    = S_DL;
          cnt_d    = '0;
          state_d  = S_DRUN;
        end
      end
      S_DL: begin
        cmd_o.op = epml_pkg::OP_LD_D;
        ret_d    = S_DD;
        cnt_d    = '0;
        state_d  = S_MRUN;
      end
      S_DD: begin
        cmd_o.op = epml_pkg::OP_D_DONE;
        state_d  = S_IDIV;
      end
      S_IDIV: begin
        cmd_o.op = epml_pkg::OP_LD_IDIV;
        ret_d    = S_IL;
        cnt_d    = '0;
        state_d  = S_KRUN;
      end
      S_IL: begin
        cmd_o.op = epml_pkg::OP_LD_I;
        ret_d    = S_I2;
        cnt_d    = '0;
        state_d  = S_MRUN;
      end
      S_I2: begin
        cmd_o.op = epml_pkg::OP_LD_I2;
        ret_d    = S_ID;
        cnt_d    = '0;
        state_d  = S_KRUN;
      end
      S_ID: begin
        cmd_o.op = epml_pkg::OP_I_DONE;
        state_d  = S_OUT;
      end
      S_OUT: begin
        // hold until the output slot is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = epml_pkg::OP_OUT;
          fire_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_MRUN: begin
        cmd_o.op = epml_pkg::OP_MUL;
        cnt_d    = cnt_q + epml_pkg::CNT_W'(1);
        if (cnt_q == epml_pkg::CNT_W'(epml_pkg::MUL_STEPS - 1)) begin
          state_d = ret_q;
        end
      end
      S_DRUN: begin
        cmd_o.op = epml_pkg::OP_DIV;
        cnt_d    = cnt_q + epml_pkg::CNT_W'(1);
        if (cnt_q == epml_pkg::CNT_W'(epml_pkg::DIV_STEPS - 1)) begin
          state_d = ret_q;
        end
      end
      S_KRUN: begin
        cmd_o.op = epml_pkg::OP_KDIV;
        cnt_d    = cnt_q + epml_pkg::CNT_W'(1);
        if (cnt_q == epml_pkg::CNT_W'(epml_pkg::KDIV_STEPS - 1)) begin
          state_d = ret_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || fire_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/epml_dpath.sv @@
`timescale 1ns / 1ps

module epml_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  epml_pkg::cmd_t                cmd_i,
  output epml_pkg::status_t             status_o,
  input  logic                          enc_b_level_i,
  input  logic [31:0]                   new_target_i,
  input  logic                          limit_level_i,
  input  logic [epml_pkg::DT_W-1:0]     dt_us_i,
  input  logic [epml_pkg::GAIN_W-1:0]   kp_i,
  input  logic [epml_pkg::GAIN_W-1:0]   kd_i,
  input  logic [epml_pkg::GAIN_W-1:0]   ki_i,
  output logic [7:0]                    pwm_duty_o,
  output logic                          reverse_o,
  output logic                          homed_flag_o
);

  localparam int unsigned IW = epml_pkg::INTEG_W;
  localparam int unsigned TW = epml_pkg::TERM_W;
  localparam int unsigned PW = epml_pkg::PROD_W;
  localparam int unsigned F  = epml_pkg::GAIN_FRAC_BITS;
  localparam int unsigned KS = epml_pkg::KDIV_SHIFT;

  // Architectural state
  logic [31:0]   pos_q, tgt_q, off_q, last_e_q;
  logic          homed_q;
  logic [IW-1:0] integ_q;

  // Per-tick working registers
  logic                        lim_q;
  logic [epml_pkg::DT_W-1:0]   dt_q;
  logic [31:0]                 e_q;
  logic [32:0]                 de_q;
  logic [TW-1:0]               p_q, d_q, i_q;

  // Shift-add multiplier
  logic [PW-1:0]                  mc_q, prod_q;
  logic [epml_pkg::MPLR_W-1:0]    mp_q;
  logic                           msign_q;

  // Restoring divider
  logic [epml_pkg::DT_W:0]        rem_q;
  logic [PW-1:0]                  quo_q;
  logic [epml_pkg::DT_W-1:0]      dvsr_q;

  // Divide-by-1000 residue
  logic [IW-1:0]                  kr_q;

  logic [7:0]    duty_q;
  logic          rev_q, hflag_q;

  logic [33:0]   e_full;
  logic [31:0]   e_sat;
  logic [52:0]   inc;
  logic [53:0]   isum;
  logic [IW-1:0] isat;
  logic [epml_pkg::DT_W+1:0] trial;
  logic [epml_pkg::DT_W:0]   shifted;
  logic [TW-1:0] u_sum, u_mag;
  logic [PW-1:0] q_d;
  logic [IW-1:0] k_a, k_r;
  logic [PW-1:0] k_q;

  assign status_o.dt_zero = (dt_q == '0);

  always_comb begin
    e_full = {{2{pos_q[31]}}, pos_q}
           - ({{2{tgt_q[31]}}, tgt_q} + {{2{off_q[31]}}, off_q});
    if (e_full[33:31] == 3'b000 || e_full[33:31] == 3'b111) begin
      e_sat = e_full[31:0];
    end else if (e_full[33]) begin
      e_sat = 32'h8000_0000;
    end else begin
      e_sat = 32'h7FFF_FFFF;
    end

    inc  = msign_q ? (~{1'b0, prod_q[51:0]} + 53'd1) : {1'b0, prod_q[51:0]};
    isum = {{6{integ_q[IW-1]}}, integ_q} + {inc[52], inc};
    if (isum[53:IW-1] == '0 || isum[53:IW-1] == '1) begin
      isat = isum[IW-1:0];
    end else if (isum[53]) begin
      isat = {1'b1, {(IW-1){1'b0}}};
    end else begin
      isat = {1'b0, {(IW-1){1'b1}}};
    end

    shifted = {rem_q[epml_pkg::DT_W-1:0], quo_q[PW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvsr_q};

    // Divide by 1000: fold each 1024 of the residue into 24 and count one,
    // then take out a last 1000 once the residue is below 1024.
    k_a = IW'(kr_q[IW-1:KS]);
    if (k_a != '0) begin
      k_r = (k_a << 4) + (k_a << 3) + IW'(kr_q[KS-1:0]);
      k_q = quo_q + PW'(k_a);
    end else if (kr_q[KS-1:0] >= epml_pkg::MILLI_DIV) begin
      k_r = IW'(kr_q[KS-1:0] - epml_pkg::MILLI_DIV);
      k_q = quo_q + PW'(1);
    end else begin
      k_r = kr_q;
      k_q = quo_q;
    end

    u_sum = p_q + d_q + i_q;
    u_mag = u_sum[TW-1] ? (~u_sum + TW'(1)) : u_sum;

    q_d = status_o.dt_zero ? '0 : quo_q;
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      tgt_q    <= epml_pkg::TARGET_RST;
      off_q    <= '0;
      homed_q  <= 1'b0;
      last_e_q <= '0;
      integ_q  <= '0;
    end else begin
      case (cmd_i.op)
        epml_pkg::OP_ENC:   pos_q <= enc_b_level_i ? pos_q + 32'd1 : pos_q - 32'd1;
        epml_pkg::OP_TGT:   tgt_q <= new_target_i;
        epml_pkg::OP_HOME: begin
          if (!homed_q && !lim_q) begin
            off_q   <= pos_q;
            tgt_q   <= '0;
            homed_q <= 1'b1;
          end
        end
        epml_pkg::OP_INTEG: integ_q  <= isat;
        epml_pkg::OP_OUT:   last_e_q <= e_q;
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      epml_pkg::OP_LATCH: begin
        lim_q <= limit_level_i;
        dt_q  <= dt_us_i;
      end
      epml_pkg::OP_ERR: e_q <= e_sat;
      epml_pkg::OP_LD_INC: begin
        de_q    <= {e_q[31], e_q} - {last_e_q[31], last_e_q};
        mc_q    <= PW'(epml_pkg::abs32(e_q));
        mp_q    <= epml_pkg::MPLR_W'(dt_q);
        prod_q  <= '0;
        msign_q <= e_q[31];
      end
      epml_pkg::OP_MUL: begin
        prod_q <= prod_q + (mp_q[0] ? mc_q : '0);
        mc_q   <= {mc_q[PW-2:0], 1'b0};
        mp_q   <= {1'b0, mp_q[epml_pkg::MPLR_W-1:1]};
      end
      epml_pkg::OP_LD_P: begin
        mc_q    <= PW'(epml_pkg::abs32(e_q));
        mp_q    <= epml_pkg::abs_gain(kp_i);
        prod_q  <= '0;
        msign_q <= e_q[31] ^ kp_i[epml_pkg::GAIN_W-1];
      end
      epml_pkg::OP_P_DONE: p_q <= epml_pkg::mk_term(msign_q, (TW-1)'(prod_q[PW-1:F]));
      epml_pkg::OP_LD_DE: begin
        mc_q    <= PW'(epml_pkg::abs33(de_q));
        mp_q    <= epml_pkg::USEC_PER_S;
        prod_q  <= '0;
        msign_q <= de_q[32];
      end
      epml_pkg::OP_LD_DDIV: begin
        rem_q  <= '0;
        quo_q  <= prod_q;
        dvsr_q <= dt_q;
      end
      epml_pkg::OP_DIV: begin
        rem_q <= trial[epml_pkg::DT_W+1] ? shifted : trial[epml_pkg::DT_W:0];
        quo_q <= {quo_q[PW-2:0], ~trial[epml_pkg::DT_W+1]};
      end
      epml_pkg::OP_LD_D: begin
        mc_q    <= PW'(epml_pkg::clamp_opnd(q_d));
        mp_q    <= epml_pkg::abs_gain(kd_i);
        prod_q  <= '0;
        msign_q <= msign_q ^ kd_i[epml_pkg::GAIN_W-1];
      end
      epml_pkg::OP_D_DONE: d_q <= epml_pkg::mk_term(msign_q, (TW-1)'(prod_q[PW-1:F]));
      epml_pkg::OP_LD_IDIV: begin
        kr_q    <= epml_pkg::abs_integ(integ_q);
        quo_q   <= '0;
        msign_q <= integ_q[IW-1];
      end
      epml_pkg::OP_KDIV: begin
        kr_q  <= k_r;
        quo_q <= k_q;
      end
      epml_pkg::OP_LD_I: begin
        mc_q    <= PW'(epml_pkg::clamp_opnd(quo_q));
        mp_q    <= epml_pkg::abs_gain(ki_i);
        prod_q  <= '0;
        msign_q <= msign_q ^ ki_i[epml_pkg::GAIN_W-1];
      end
      epml_pkg::OP_LD_I2: begin
        kr_q  <= prod_q[PW-1:F];
        quo_q <= '0;
      end
      epml_pkg::OP_I_DONE: i_q <= epml_pkg::mk_term(msign_q, quo_q[TW-2:0]);
      epml_pkg::OP_OUT: begin
        duty_q  <= (u_mag > TW'(epml_pkg::DUTY_MAX)) ? epml_pkg::DUTY_MAX : u_mag[7:0];
        rev_q   <= u_sum[TW-1];
        hflag_q <= homed_q;
      end
      default: ;
    endcase
  end

  assign pwm_duty_o   = duty_q;
  assign reverse_o    = rev_q;
  assign homed_flag_o = hflag_q;

endmodule

@@ rtl/core/encoder_pid_motor_position_loop_top.sv @@
`timescale 1ns / 1ps
// Encoder edge and set-target requests complete in the accept cycle.
// A control tick raises its result after the shift-add multiplier (5 passes), the
// derivative divider (skipped when dt_us is 0) and two divide-by-1000 passes; it waits
// while an earlier result is still pending. One request is in flight.
// Reset (async, active low) clears position, offset, homing, integral and last error,
// loads the target with -5000 and the gains with their default values.
module encoder_pid_motor_position_loop_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic        enc_b_level_i,
  input  logic [31:0] new_target_i,
  input  logic        limit_level_i,
  input  logic [19:0] dt_us_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pwm_duty_o,
  output logic        reverse_o,
  output logic        homed_flag_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [epml_pkg::GAIN_W-1:0] kp_q, kd_q, ki_q;
  logic                        cfg_wr;
  epml_pkg::cmd_t              cmd;
  epml_pkg::status_t           status;

  // Gain registers: write on the access phase, read back sign-extended.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= epml_pkg::KP_RST;
      kd_q <= epml_pkg::KD_RST;
      ki_q <= epml_pkg::KI_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        epml_pkg::REG_KP: kp_q <= pwdata[epml_pkg::GAIN_W-1:0];
        epml_pkg::REG_KD: kd_q <= pwdata[epml_pkg::GAIN_W-1:0];
        epml_pkg::REG_KI: ki_q <= pwdata[epml_pkg::GAIN_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      epml_pkg::REG_KP: prdata = {{8{kp_q[epml_pkg::GAIN_W-1]}}, kp_q};
      epml_pkg::REG_KD: prdata = {{8{kd_q[epml_pkg::GAIN_W-1]}}, kd_q};
      epml_pkg::REG_KI: prdata = {{8{ki_q[epml_pkg::GAIN_W-1]}}, ki_q};
      default:          prdata = '0;
    endcase
  end

  // Sequencer: accepts requests, steps the datapath through a tick.
  epml_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Datapath: position state, PID arithmetic, result register.
  epml_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .enc_b_level_i (enc_b_level_i),
    .new_target_i  (new_target_i),
    .limit_level_i (limit_level_i),
    .dt_us_i       (dt_us_i),
    .kp_i          (kp_q),
    .kd_i          (kd_q),
    .ki_i          (ki_q),
    .pwm_duty_o    (pwm_duty_o),
    .reverse_o     (reverse_o),
    .homed_flag_o  (homed_flag_o)
  );

  // Never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == epml_pkg::OP_OUT |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten while pending");

  // A tick request keeps the block busy in the next cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i == epml_pkg::REQ_TICK) |=> !in_ready_o)
    else $error("tick request did not start processing");

  // The derivative divide never runs with a zero interval.
  a_no_div_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == epml_pkg::OP_LD_DDIV |-> !status.dt_zero)
    else $error("divide started with zero interval");

endmodule
